// File: src/tun_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

	localparam int FIELD_W    = 24;
	localparam int OUT_W      = 16;
	localparam int SCALE_BITS = 15;
	localparam int QUEUE_DEPTH = 4;

	typedef logic signed [FIELD_W-1:0] coord_t;
	typedef logic signed [OUT_W-1:0]   comp_t;

	// normal given for a zero-area face
	localparam comp_t DEGEN_VALUE = 16'sd18919;
	localparam comp_t NEG_FULL    = 16'sh8000;

endpackage

`default_nettype wire

// File: src/tun_vtx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tun_vtx_if;
	logic           valid;
	logic           ready;
	tun_pkg::coord_t ax, ay, az;
	tun_pkg::coord_t bx, by, bz;
	tun_pkg::coord_t cx, cy, cz;

	modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
	modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

`default_nettype wire

// File: src/tun_nrm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tun_nrm_if;
	logic           valid;
	logic           ready;
	tun_pkg::comp_t nx, ny, nz;
	logic           degenerate;

	modport source(output valid, nx, ny, nz, degenerate, input ready);
	modport sink(input valid, nx, ny, nz, degenerate, output ready);
endinterface

`default_nettype wire

// File: src/tun_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tun_vtx_if.sink                          vtx,
	input  logic                             full,
	output logic                             push,
	output logic [2:0]                       sgn,
	output logic [2:0][2*COORD_BITS:0]       mag,
	output logic [4*COORD_BITS+3:0]          sq_sum,
	output logic                             degen
);

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int P  = 2 * D;
	localparam int M  = 2 * C + 1;
	localparam int K  = C + 1;
	localparam int H  = M - K;
	localparam int SQ = 4 * C + 2;
	localparam int SW = 4 * C + 4;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [D-1:0] a_e [3];
	logic signed [D-1:0] b_e [3];
	logic signed [D-1:0] c_e [3];

	assign a_e[0] = {vtx.ax[C-1], vtx.ax[C-1:0]};
	assign a_e[1] = {vtx.ay[C-1], vtx.ay[C-1:0]};
	assign a_e[2] = {vtx.az[C-1], vtx.az[C-1:0]};
	assign b_e[0] = {vtx.bx[C-1], vtx.bx[C-1:0]};
	assign b_e[1] = {vtx.by[C-1], vtx.by[C-1:0]};
	assign b_e[2] = {vtx.bz[C-1], vtx.bz[C-1:0]};
	assign c_e[0] = {vtx.cx[C-1], vtx.cx[C-1:0]};
	assign c_e[1] = {vtx.cy[C-1], vtx.cy[C-1:0]};
	assign c_e[2] = {vtx.cz[C-1], vtx.cz[C-1:0]};

	logic signed [D-1:0] u_s1 [3];
	logic signed [D-1:0] v_s1 [3];
	logic signed [P-1:0] p_s2 [6];
	logic signed [P-1:0] n_c  [3];
	logic        [P-1:0] a_c  [3];
	logic [2:0]             sgn_s3, sgn_s4, sgn_s5, sgn_s6;
	logic [2:0][M-1:0]      mag_s3, mag_s4, mag_s5, mag_s6;
	logic                   dg_s3, dg_s4, dg_s5, dg_s6;
	logic [2:0][2*K-1:0]    ll_s4;
	logic [2:0][M-1:0]      hl_s4;
	logic [2:0][2*H-1:0]    hh_s4;
	logic [2:0][SQ-1:0]     sq_s5;
	logic [SW-1:0]          sum_s6;

	assign en        = !vld_s6 || !full;
	assign vtx.ready = en;
	assign push      = vld_s6 && !full;

	// cross product terms: x = uy*vz - uz*vy, y = uz*vx - ux*vz, z = ux*vy - uy*vx
	assign n_c[0] = p_s2[0] - p_s2[1];
	assign n_c[1] = p_s2[2] - p_s2[3];
	assign n_c[2] = p_s2[4] - p_s2[5];

	for (genvar i = 0; i < 3; i++) begin : g_abs
		assign a_c[i] = n_c[i][P-1] ? P'(-n_c[i]) : P'(n_c[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vtx.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= b_e[i] - a_e[i];
				v_s1[i] <= c_e[i] - a_e[i];
			end

			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= u_s1[2] * v_s1[1];
			p_s2[2] <= u_s1[2] * v_s1[0];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= u_s1[1] * v_s1[0];

			for (int i = 0; i < 3; i++) begin
				sgn_s3[i] <= n_c[i][P-1];
				mag_s3[i] <= a_c[i][M-1:0];
			end
			dg_s3 <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);

			// square split in halves to keep each multiplier narrow
			for (int i = 0; i < 3; i++) begin
				ll_s4[i] <= mag_s3[i][K-1:0] * mag_s3[i][K-1:0];
				hl_s4[i] <= mag_s3[i][M-1:K] * mag_s3[i][K-1:0];
				hh_s4[i] <= mag_s3[i][M-1:K] * mag_s3[i][M-1:K];
			end
			sgn_s4 <= sgn_s3;
			mag_s4 <= mag_s3;
			dg_s4  <= dg_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (SQ'(hh_s4[i]) << (2 * K)) + (SQ'(hl_s4[i]) << (K + 1))
					+ SQ'(ll_s4[i]);
			end
			sgn_s5 <= sgn_s4;
			mag_s5 <= mag_s4;
			dg_s5  <= dg_s4;

			sum_s6 <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
			sgn_s6 <= sgn_s5;
			mag_s6 <= mag_s5;
			dg_s6  <= dg_s5;
		end
	end

	assign sgn    = sgn_s6;
	assign mag    = mag_s6;
	assign sq_sum = sum_s6;
	assign degen  = dg_s6;

endmodule

`default_nettype wire

// File: src/tun_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tun_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && full && !do_pop) |=> (cnt_q == CW'(DEPTH)))
		else $error("queue lost its fill while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: src/tun_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tun_back #(
	parameter int COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        pop,
	input  logic [2:0]                  sgn,
	input  logic [2:0][2*COORD_BITS:0]  mag,
	input  logic [4*COORD_BITS+3:0]     sq_sum,
	input  logic                        degen,
	tun_nrm_if.source                   nrm
);

	localparam int C  = COORD_BITS;
	localparam int M  = 2 * C + 1;
	localparam int SW = 4 * C + 4;
	localparam int R  = 2 * C + 2;
	localparam int SB = tun_pkg::SCALE_BITS;
	localparam int XW = M + SB;
	localparam int LW = R + SB;

	logic en;

	// square root, one root bit per stage
	logic              vld_s  [R+1];
	logic [SW-1:0]     rem_s  [R+1];
	logic [R-1:0]      root_s [R+1];
	logic [2:0]        sgn_s  [R+1];
	logic [2:0][M-1:0] mag_s  [R+1];
	logic              dg_s   [R+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = sq_sum;
	assign root_s[0] = '0;
	assign sgn_s[0]  = sgn;
	assign mag_s[0]  = mag;
	assign dg_s[0]   = degen;
	assign pop       = en && in_valid;

	for (genvar g = 0; g < R; g++) begin : g_sqrt
		localparam int B = R - 1 - g;
		logic [SW:0] trial;
		logic        take;

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign trial = ((SW+1)'(root_s[g]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_s[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else if (en)
				vld_s[g+1] <= vld_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= take ? rem_s[g] - trial[SW-1:0] : rem_s[g];
				root_s[g+1] <= take ? (root_s[g] | (R'(1) << B)) : root_s[g];
				sgn_s[g+1]  <= sgn_s[g];
				mag_s[g+1]  <= mag_s[g];
				dg_s[g+1]   <= dg_s[g];
			end
		end
	end

	// scaling division, one quotient bit per stage
	logic               dv_vld_s [SB+1];
	logic [2:0][XW-1:0] dv_rem_s [SB+1];
	logic [2:0][SB-1:0] dv_q_s   [SB+1];
	logic [R-1:0]       dv_len_s [SB+1];
	logic [2:0]         dv_sgn_s [SB+1];
	logic               dv_dg_s  [SB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (en)
			dv_vld_s[0] <= vld_s[R];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				// m * 32767
				dv_rem_s[0][i] <= (XW'(mag_s[R][i]) << SB) - XW'(mag_s[R][i]);
				dv_q_s[0][i]   <= '0;
			end
			dv_len_s[0] <= (root_s[R] == '0) ? R'(1) : root_s[R];
			dv_sgn_s[0] <= sgn_s[R];
			dv_dg_s[0]  <= dg_s[R];
		end
	end

	for (genvar k = 0; k < SB; k++) begin : g_div
		localparam int B = SB - 1 - k;
		logic [LW-1:0] dsh;
		logic [2:0]    take;

		assign dsh = LW'(dv_len_s[k]) << B;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			assign take[i] = LW'(dv_rem_s[k][i]) >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k+1] <= 1'b0;
			else if (en)
				dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= take[i] ? dv_rem_s[k][i] - dsh[XW-1:0]
						: dv_rem_s[k][i];
					dv_q_s[k+1][i]   <= take[i] ? (dv_q_s[k][i] | (SB'(1) << B))
						: dv_q_s[k][i];
				end
				dv_len_s[k+1] <= dv_len_s[k];
				dv_sgn_s[k+1] <= dv_sgn_s[k];
				dv_dg_s[k+1]  <= dv_dg_s[k];
			end
		end
	end

	// output register; a 15-bit quotient is never above 32767
	logic           out_vld_q;
	tun_pkg::comp_t cmp [3];
	tun_pkg::comp_t nx_q, ny_q, nz_q;
	logic           dg_q;

	for (genvar i = 0; i < 3; i++) begin : g_sign
		assign cmp[i] = dv_dg_s[SB] ? tun_pkg::DEGEN_VALUE
			: dv_sgn_s[SB][i] ? -tun_pkg::comp_t'(dv_q_s[SB][i])
			: tun_pkg::comp_t'(dv_q_s[SB][i]);
	end

	assign en = !out_vld_q || nrm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= dv_vld_s[SB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q <= cmp[0];
			ny_q <= cmp[1];
			nz_q <= cmp[2];
			dg_q <= dv_dg_s[SB];
		end
	end

	assign nrm.valid      = out_vld_q;
	assign nrm.nx         = nx_q;
	assign nrm.ny         = ny_q;
	assign nrm.nz         = nz_q;
	assign nrm.degenerate = dg_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(nrm.valid && nrm.degenerate) |-> (nrm.nx == tun_pkg::DEGEN_VALUE
		&& nrm.ny == tun_pkg::DEGEN_VALUE && nrm.nz == tun_pkg::DEGEN_VALUE))
		else $error("degenerate beat without default normal");
	assert property (@(posedge clk) disable iff (!arst_n)
		(nrm.valid && !nrm.degenerate) |-> (nrm.nx != tun_pkg::NEG_FULL
		&& nrm.ny != tun_pkg::NEG_FULL && nrm.nz != tun_pkg::NEG_FULL))
		else $error("normal component out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[R] && !dg_s[R]) |-> (root_s[R] != '0))
		else $error("zero length for a non-degenerate face");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && en) |=> vld_s[1])
		else $error("popped item did not enter the root pipeline");

endmodule

`default_nettype wire

// File: src/triangle_unit_normal.sv
// Stages: a triangle accepted on vtx passes 6 front stages, the queue, one root bit per
// stage (2*COORD_BITS+2), one prep stage, 15 divide stages and the output register.
// Throughput: one triangle per cycle unless a full queue stalls the front or a low
// nrm.ready stalls the back; a 4-entry queue sits between front and back.
// Reset: arst_n clears all valid bits and queue pointers; data registers keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal #(
	parameter int COORD_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	tun_vtx_if.sink    vtx,
	tun_nrm_if.source  nrm
);

	localparam int M  = 2 * COORD_BITS + 1;
	localparam int SW = 4 * COORD_BITS + 4;
	localparam int QW = 3 + 3 * M + SW + 1;

	logic              push, full, q_valid, pop;
	logic [2:0]        f_sgn, b_sgn;
	logic [2:0][M-1:0] f_mag, b_mag;
	logic [SW-1:0]     f_sum, b_sum;
	logic              f_dg, b_dg;
	logic [QW-1:0]     q_rdata;

	tun_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.full   (full),
		.push   (push),
		.sgn    (f_sgn),
		.mag    (f_mag),
		.sq_sum (f_sum),
		.degen  (f_dg)
	);

	tun_fifo #(.WIDTH(QW), .DEPTH(tun_pkg::QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_sgn, f_mag, f_sum, f_dg}),
		.full   (full),
		.pop    (pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign {b_sgn, b_mag, b_sum, b_dg} = q_rdata;

	tun_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.pop      (pop),
		.sgn      (b_sgn),
		.mag      (b_mag),
		.sq_sum   (b_sum),
		.degen    (b_dg),
		.nrm      (nrm)
	);

endmodule

`default_nettype wire
